### src/ssd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

    // Result kinds seen on the output channel.
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_END_GOOD = 2'd1;
    localparam logic [1:0] KIND_END_BAD  = 2'd2;

    // Link framing constants.
    localparam logic [7:0] SYNC_FIRST  = 8'h01;
    localparam logic [7:0] SYNC_SECOND = 8'hFE;
    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [7:0] HDR_LEN     = 8'd16;
    localparam logic [7:0] LEN_POS     = 8'd6;
    localparam logic [7:0] GROUP_LEN   = 8'd7;

    // Body byte offsets of the start marker, the latched fields and the first group.
    localparam logic [7:0] BODY_START  = 8'd0;
    localparam logic [7:0] BODY_MSG    = 8'd2;
    localparam logic [7:0] BODY_CMD    = 8'd4;
    localparam logic [7:0] BODY_SUB    = 8'd5;
    localparam logic [7:0] BODY_GROUPS = 8'd6;

    // One result item.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] msg_num;
        logic [7:0] cmd;
        logic [7:0] sub;
        logic [7:0] payload_count;
    } res_t;

    // Result handoff from the parser to the output queue.
    typedef struct packed {
        logic push;
        res_t res;
    } res_push_t;

endpackage

`default_nettype wire

### src/ssd_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Received byte channel.
interface ssd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// Result channel.
interface ssd_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] msg_num;
    logic [7:0] cmd;
    logic [7:0] sub;
    logic [7:0] payload_count;

    modport source (output valid, output kind, output data, output msg_num,
                    output cmd, output sub, output payload_count, input ready);
    modport sink (input valid, input kind, input data, input msg_num,
                  input cmd, input sub, input payload_count, output ready);
endinterface

`default_nettype wire

### src/ssd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module ssd_parser
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_fire,
    input  wire logic [7:0]        rx_byte,
    output ssd_pkg::res_push_t     res_push
);

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_SYNC  = 2'd1,
        PH_FRAME = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] plen_reg, plen_next;
    logic [7:0] msg_reg, msg_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] sub_reg, sub_next;
    logic       smo_reg, smo_next;
    logic [6:0] prefix_reg, prefix_next;
    logic [2:0] slot_reg, slot_next;
    logic [7:0] count_reg, count_next;

    logic [7:0] len_v;
    logic [7:0] flen;
    logic [7:0] body_idx;
    logic [7:0] prefix_ext;
    logic       hi_bit;
    logic       emit;
    logic [7:0] dec_val;
    logic       frame_end;
    logic       frame_good;
    logic       push;
    logic [1:0] kind;
    logic [7:0] data;

    // Packet length as seen by this byte, and the body length derived from it.
    assign len_v    = (pos_reg == ssd_pkg::LEN_POS) ? rx_byte : plen_reg;
    assign flen     = (len_v >= ssd_pkg::HDR_LEN) ? (len_v - ssd_pkg::HDR_LEN) : 8'd0;
    assign body_idx = pos_reg - ssd_pkg::HDR_LEN;
    // Slot k takes its high bit from prefix bit k-1; slot 0 never decodes.
    assign prefix_ext = {1'b0, prefix_reg};
    assign hi_bit     = prefix_ext[slot_reg - 3'd1];
    assign dec_val  = {hi_bit, rx_byte[6:0]} | {1'b0, rx_byte[6:0]} | {rx_byte[7], 7'd0};

    // Next-state and result logic for one accepted byte.
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        plen_next   = plen_reg;
        msg_next    = msg_reg;
        cmd_next    = cmd_reg;
        sub_next    = sub_reg;
        smo_next    = smo_reg;
        prefix_next = prefix_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        emit        = 1'b0;
        frame_end   = 1'b0;
        frame_good  = 1'b0;

        unique case (phase_reg)
            PH_SYNC:
            begin
                if (rx_byte == ssd_pkg::SYNC_SECOND)
                begin
                    phase_next  = PH_FRAME;
                    pos_next    = 8'd2;
                    plen_next   = 8'd0;
                    msg_next    = 8'd0;
                    cmd_next    = 8'd0;
                    sub_next    = 8'd0;
                    smo_next    = 1'b0;
                    prefix_next = 7'd0;
                    slot_next   = 3'd0;
                    count_next  = 8'd0;
                end
                else if (rx_byte != ssd_pkg::SYNC_FIRST)
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_FRAME:
            begin
                if (pos_reg == ssd_pkg::LEN_POS)
                begin
                    plen_next = rx_byte;
                end
                if ((pos_reg == ssd_pkg::LEN_POS) && (rx_byte < ssd_pkg::HDR_LEN))
                begin
                    // Length too short to hold a header: resume the sync search.
                    phase_next = PH_HUNT;
                    pos_next   = 8'd0;
                end
                else
                begin
                    // Body field latching and 7-bit group unpacking.
                    if (pos_reg >= ssd_pkg::HDR_LEN)
                    begin
                        if (body_idx == ssd_pkg::BODY_START)
                        begin
                            smo_next = (rx_byte == ssd_pkg::SYSEX_START);
                        end
                        else if (body_idx == ssd_pkg::BODY_MSG)
                        begin
                            msg_next = rx_byte;
                        end
                        else if (body_idx == ssd_pkg::BODY_CMD)
                        begin
                            cmd_next = rx_byte;
                        end
                        else if (body_idx == ssd_pkg::BODY_SUB)
                        begin
                            sub_next = rx_byte;
                        end
                        else if ((body_idx >= ssd_pkg::BODY_GROUPS) &&
                                 (({1'b0, body_idx} + 9'd1) < {1'b0, flen}))
                        begin
                            if (slot_reg == 3'd0)
                            begin
                                prefix_next = rx_byte[6:0];
                                slot_next   = 3'd1;
                            end
                            else
                            begin
                                emit = 1'b1;
                                if (count_reg != 8'hFF)
                                begin
                                    count_next = count_reg + 8'd1;
                                end
                                slot_next = ({5'd0, slot_reg} >= ssd_pkg::GROUP_LEN) ?
                                            3'd0 : (slot_reg + 3'd1);
                            end
                        end
                    end

                    // Last packet byte closes the frame.
                    if ((pos_reg > ssd_pkg::LEN_POS) &&
                        (({1'b0, pos_reg} + 9'd1) == {1'b0, len_v}))
                    begin
                        frame_end  = 1'b1;
                        frame_good = (flen >= ssd_pkg::GROUP_LEN) && smo_next &&
                                     (rx_byte == ssd_pkg::SYSEX_END);
                        phase_next = PH_HUNT;
                        pos_next   = 8'd0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 8'd1;
                    end
                end
            end
            default:
            begin
                phase_next = (rx_byte == ssd_pkg::SYNC_FIRST) ? PH_SYNC : PH_HUNT;
            end
        endcase
    end

    // Result formation: a frame end takes precedence over a decoded byte.
    always_comb
    begin
        push = byte_fire && (frame_end || emit);
        if (frame_end)
        begin
            kind = frame_good ? ssd_pkg::KIND_END_GOOD : ssd_pkg::KIND_END_BAD;
            data = 8'd0;
        end
        else
        begin
            kind = ssd_pkg::KIND_DATA;
            data = dec_val;
        end
    end

    assign res_push.push              = push;
    assign res_push.res.kind          = kind;
    assign res_push.res.data          = data;
    assign res_push.res.msg_num       = msg_next;
    assign res_push.res.cmd           = cmd_next;
    assign res_push.res.sub           = sub_next;
    assign res_push.res.payload_count = count_next;

    // Parser state, updated once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            pos_reg    <= 8'd0;
            plen_reg   <= 8'd0;
            msg_reg    <= 8'd0;
            cmd_reg    <= 8'd0;
            sub_reg    <= 8'd0;
            smo_reg    <= 1'b0;
            prefix_reg <= 7'd0;
            slot_reg   <= 3'd0;
            count_reg  <= 8'd0;
        end
        else if (byte_fire)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            plen_reg   <= plen_next;
            msg_reg    <= msg_next;
            cmd_reg    <= cmd_next;
            sub_reg    <= sub_next;
            smo_reg    <= smo_next;
            prefix_reg <= prefix_next;
            slot_reg   <= slot_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### src/ssd_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ssd_out_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ssd_pkg::res_push_t res_push,
    output logic                   full,
    ssd_res_if.source              res
);

    ssd_pkg::res_t mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          pop;
    ssd_pkg::res_t head;

    // Two result slots so the parser keeps running while one result waits.
    assign full = (count_reg == 2'd2);
    assign pop  = (count_reg != 2'd0) && res.ready;
    assign head = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = res_push.push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, res_push.push} - {1'b0, pop};
    end

    // Pointer and fill-level registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (res_push.push)
        begin
            mem_reg[wr_ptr_reg] <= res_push.res;
        end
    end

    assign res.valid         = (count_reg != 2'd0);
    assign res.kind          = head.kind;
    assign res.data          = head.data;
    assign res.msg_num       = head.msg_num;
    assign res.cmd           = head.cmd;
    assign res.sub           = head.sub;
    assign res.payload_count = head.payload_count;

endmodule

`default_nettype wire

### src/sysex_stream_deframer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// SysEx stream deframer.
// The rx channel carries one link byte per transaction. The block hunts for the
// sync pair 0x01 0xFE, reads the 16-byte header (byte 6 is the packet length),
// then unpacks the 7-bit groups of the SysEx body. Each decoded byte leaves on
// the res channel as a payload result; the last packet byte gives a frame-end
// result, good or bad. On a bad end the receiver drops that frame's bytes.
// A byte can be accepted every cycle while the output queue has room. Header,
// marker and prefix bytes cause no result unless they are the last packet byte.
// The per-byte parser update is a single register stage; results go into a
// two-entry output queue that offers them on res. When the receiver stalls, up
// to two results are held, after which rx.ready drops until a result is taken.
// Reset clears the parser to the sync search and empties the output queue;
// no clearing pass is needed.
module sysex_stream_deframer_core
(
    input  wire logic clk,
    input  wire logic rst_n,
    ssd_rx_if.sink    rx,
    ssd_res_if.source res
);

    ssd_pkg::res_push_t res_push;
    logic               queue_full;
    logic               byte_fire;

    // An rx transaction is taken whenever the output queue has room.
    assign rx.ready  = !queue_full;
    assign byte_fire = rx.valid && !queue_full;

    ssd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_fire (byte_fire),
        .rx_byte   (rx.rx_byte),
        .res_push  (res_push)
    );

    ssd_out_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .full     (queue_full),
        .res      (res)
    );

endmodule

`default_nettype wire

### src/ssd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ssd_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [1:0] res_kind,
    input wire logic [7:0] res_data,
    input wire logic [7:0] res_payload_count
);

    // A stalled result stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result withdrawn while stalled");

    // Only the three defined result kinds appear.
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_kind == ssd_pkg::KIND_DATA ||
                       res_kind == ssd_pkg::KIND_END_GOOD ||
                       res_kind == ssd_pkg::KIND_END_BAD))
        else $error("undefined result kind");

    // Frame-end results carry a zero data byte.
    a_end_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_kind != ssd_pkg::KIND_DATA) |-> (res_data == 8'd0))
        else $error("frame end with nonzero data");

    // A payload byte is always counted.
    a_data_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_kind == ssd_pkg::KIND_DATA) |-> (res_payload_count != 8'd0))
        else $error("payload byte with zero count");

endmodule

bind sysex_stream_deframer_core ssd_checker u_ssd_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_kind          (res.kind),
    .res_data          (res.data),
    .res_payload_count (res.payload_count)
);

`default_nettype wire

### tb/ssd_deframer_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the deframer, predicts the result of every
// accepted link byte and compares the results taken from the block in order.
module ssd_deframer_checker
    import ssd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ssd_rx_if         rx,
    ssd_res_if        res,
    output int        mismatch_count,
    output int        outstanding,
    output int        bytes_seen,
    output int        results_seen,
    output int        good_ends,
    output int        bad_ends
);

    // Link state of the predicted parser.
    typedef enum logic [1:0]
    {
        HUNTING   = 2'd0,
        SYNC_SEEN = 2'd1,
        IN_PACKET = 2'd2
    } link_state_t;

    link_state_t link_state;
    logic [7:0]  pos;
    logic [7:0]  pkt_len;
    logic [7:0]  msg_latch;
    logic [7:0]  cmd_latch;
    logic [7:0]  sub_latch;
    logic [7:0]  decoded;
    logic        start_seen;
    logic [6:0]  hi_bits;
    logic [2:0]  slot;

    // Results predicted but not yet seen on the result channel.
    res_t pending_results[$];

    // Builds a result carrying the fields latched for the current frame.
    function automatic res_t frame_result(input logic [1:0] kind, input logic [7:0] data);
        res_t r;
        r.kind          = kind;
        r.data          = data;
        r.msg_num       = msg_latch;
        r.cmd           = cmd_latch;
        r.sub           = sub_latch;
        r.payload_count = decoded;
        return r;
    endfunction

    // Advances the predicted parser by one link byte. Returns 1 when the byte
    // produces a result, which is then placed in r.
    function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
        int         p;
        int         len;
        int         flen;
        int         s;
        int         k;
        bit         emit;
        logic [7:0] val;
        logic [1:0] end_kind;

        emit = 1'b0;
        val  = 8'h00;
        r    = '0;

        // Second byte of the sync pair; a repeated first byte keeps waiting.
        if (link_state == SYNC_SEEN)
        begin
            if (b == SYNC_SECOND)
            begin
                link_state = IN_PACKET;
                pos        = 8'd2;
                pkt_len    = 8'h00;
                msg_latch  = 8'h00;
                cmd_latch  = 8'h00;
                sub_latch  = 8'h00;
                start_seen = 1'b0;
                hi_bits    = 7'h00;
                slot       = 3'd0;
                decoded    = 8'h00;
            end
            else if (b != SYNC_FIRST)
            begin
                link_state = HUNTING;
            end
            return 1'b0;
        end
        if (link_state != IN_PACKET)
        begin
            link_state = (b == SYNC_FIRST) ? SYNC_SEEN : HUNTING;
            return 1'b0;
        end

        // Header byte with the packet length; a length below the header
        // size sends the parser back to hunting without a result.
        p = int'(pos);
        if (p == int'(LEN_POS))
        begin
            pkt_len = b;
            if (b < HDR_LEN)
            begin
                link_state = HUNTING;
                pos        = 8'h00;
                return 1'b0;
            end
        end
        len  = int'(pkt_len);
        flen = (len >= int'(HDR_LEN)) ? len - int'(HDR_LEN) : 0;

        // SysEx body: markers, latched fields and the 7-bit groups.
        if (p >= int'(HDR_LEN))
        begin
            s = p - int'(HDR_LEN);
            if (s == int'(BODY_START))
            begin
                start_seen = (b == SYSEX_START);
            end
            else if (s == int'(BODY_MSG))
            begin
                msg_latch = b;
            end
            else if (s == int'(BODY_CMD))
            begin
                cmd_latch = b;
            end
            else if (s == int'(BODY_SUB))
            begin
                sub_latch = b;
            end
            else if (s >= int'(BODY_GROUPS) && s + 1 < flen)
            begin
                if (slot == 3'd0)
                begin
                    hi_bits = b[6:0];
                    slot    = 3'd1;
                end
                else
                begin
                    k   = int'(slot);
                    val = {b[7] | hi_bits[k - 1], b[6:0]};
                    if (decoded != 8'hFF)
                    begin
                        decoded = decoded + 8'd1;
                    end
                    slot = (k >= int'(GROUP_LEN)) ? 3'd0 : 3'(k + 1);
                    emit = 1'b1;
                end
            end
        end

        // Last packet byte closes the frame, good or bad.
        if (p > int'(LEN_POS) && p + 1 == len)
        begin
            end_kind = (flen >= int'(GROUP_LEN) && start_seen && b == SYSEX_END)
                       ? KIND_END_GOOD : KIND_END_BAD;
            r          = frame_result(end_kind, 8'h00);
            link_state = HUNTING;
            pos        = 8'h00;
            return 1'b1;
        end

        pos = 8'(p + 1);
        if (emit)
        begin
            r = frame_result(KIND_DATA, val);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Counts a mismatch and reports the first few in full.
    task automatic flag_mismatch(input string what, input res_t want, input res_t got);
        if (mismatch_count < 10)
        begin
            $display("Mismatch (%s) at %0t: expected kind=%0d data=%02h msg=%02h",
                     what, $time, want.kind, want.data, want.msg_num);
            $display("    expected cmd=%02h sub=%02h count=%0d",
                     want.cmd, want.sub, want.payload_count);
            $display("    got kind=%0d data=%02h msg=%02h cmd=%02h sub=%02h count=%0d",
                     got.kind, got.data, got.msg_num, got.cmd, got.sub, got.payload_count);
        end
        mismatch_count++;
    endtask

    // Compare taken results first, then predict the byte of this cycle, so a
    // result is never matched against an expectation made in the same cycle.
    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        res_t predicted;

        if (!rst_n)
        begin
            link_state     = HUNTING;
            pos            = 8'h00;
            pkt_len        = 8'h00;
            msg_latch      = 8'h00;
            cmd_latch      = 8'h00;
            sub_latch      = 8'h00;
            decoded        = 8'h00;
            start_seen     = 1'b0;
            hi_bits        = 7'h00;
            slot           = 3'd0;
            pending_results.delete();
            mismatch_count = 0;
            outstanding    = 0;
            bytes_seen     = 0;
            results_seen   = 0;
            good_ends      = 0;
            bad_ends       = 0;
        end
        else
        begin
            // Result transaction.
            if (res.valid && res.ready)
            begin
                got.kind          = res.kind;
                got.data          = res.data;
                got.msg_num       = res.msg_num;
                got.cmd           = res.cmd;
                got.sub           = res.sub;
                got.payload_count = res.payload_count;
                results_seen++;
                if (got.kind == KIND_END_GOOD)
                begin
                    good_ends++;
                end
                else if (got.kind == KIND_END_BAD)
                begin
                    bad_ends++;
                end
                if (pending_results.size() == 0)
                begin
                    flag_mismatch("unexpected result", '0, got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind || got.data !== want.data ||
                        got.msg_num !== want.msg_num || got.cmd !== want.cmd ||
                        got.sub !== want.sub || got.payload_count !== want.payload_count)
                    begin
                        flag_mismatch("wrong field", want, got);
                    end
                end
            end

            // Link byte transaction.
            if (rx.valid && rx.ready)
            begin
                bytes_seen++;
                if (deframe_byte(rx.rx_byte, predicted))
                begin
                    pending_results.push_back(predicted);
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// Drives link bytes into the deframer with random gaps and stalls, and gives
// the verdict from the checker's count of mismatches.
module tb;
    import ssd_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 2000;
    localparam int BYTE_GOAL   = 1700;
    localparam int NO_CUT      = 1000;

    logic clk = 1'b0;
    logic rst_n;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int bytes_sent;
    int quiet_cycles;

    int mismatch_count;
    int outstanding;
    int bytes_seen;
    int results_seen;
    int good_ends;
    int bad_ends;

    always #2 clk = ~clk;

    ssd_rx_if  rx_ch ();
    ssd_res_if res_ch ();

    sysex_stream_deframer_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    ssd_deframer_checker chk
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx             (rx_ch),
        .res            (res_ch),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .bytes_seen     (bytes_seen),
        .results_seen   (results_seen),
        .good_ends      (good_ends),
        .bad_ends       (bad_ends)
    );

    // Offers one link byte after a random gap and waits for its transaction.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // Sends a packet of the given length (only up to the length byte if it is
    // under the header size) with random content. The markers can be broken on
    // purpose, and the packet can be cut short after a given number of bytes.
    task automatic send_frame(input int len, input bit good_start, input bit good_end,
                              input int cut);
        int         flen;
        int         last;
        int         s;
        logic [7:0] b;

        flen = (len >= int'(HDR_LEN)) ? len - int'(HDR_LEN) : 0;
        last = (len < int'(HDR_LEN)) ? int'(LEN_POS) + 1 : len;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        for (int p = 2; p < last && p < cut; p++)
        begin
            b = 8'($urandom_range(255));
            if (p == int'(LEN_POS))
            begin
                b = 8'(len);
            end
            else if (p >= int'(HDR_LEN))
            begin
                s = p - int'(HDR_LEN);
                if (s == flen - 1)
                begin
                    if (good_end)
                    begin
                        b = SYSEX_END;
                    end
                    else if (b == SYSEX_END)
                    begin
                        b = ~b;
                    end
                end
                else if (s == int'(BODY_START))
                begin
                    if (good_start)
                    begin
                        b = SYSEX_START;
                    end
                    else if (b == SYSEX_START)
                    begin
                        b = ~b;
                    end
                end
            end
            send_byte(b);
        end
    endtask

    // Mostly well-formed packets with random content, mixed with broken
    // markers, short bodies, bad lengths, cut packets and line noise.
    task automatic send_random_traffic(input int byte_goal);
        int       pick;
        int       len;
        bit [1:0] broken;

        while (bytes_sent < byte_goal)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(9) == 0)
            begin
                send_byte(SYNC_FIRST);
            end
            if (pick < 1)
            begin
                len = ($urandom_range(1) != 0) ? 255 : int'($urandom_range(254, 200));
                send_frame(len, 1'b1, 1'b1, NO_CUT);
            end
            else if (pick < 68)
            begin
                send_frame($urandom_range(48, 23), 1'b1, 1'b1, NO_CUT);
            end
            else if (pick < 76)
            begin
                broken = 2'($urandom_range(3, 1));
                send_frame($urandom_range(48, 23), !broken[0], !broken[1], NO_CUT);
            end
            else if (pick < 84)
            begin
                send_frame($urandom_range(22, 16), 1'b1, 1'b1, NO_CUT);
            end
            else if (pick < 90)
            begin
                send_frame($urandom_range(15, 0), 1'b1, 1'b1, NO_CUT);
            end
            else if (pick < 95)
            begin
                len = $urandom_range(48, 23);
                send_frame(len, 1'b1, 1'b1, $urandom_range(len - 1, 3));
            end
            else
            begin
                // A sync start followed by a byte that is neither sync byte.
                send_byte(SYNC_FIRST);
                send_byte(8'($urandom_range(253, 2)));
            end
            repeat ($urandom_range(2, 0))
            begin
                send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        int holds_served;

        holds_served = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                begin
                    @(posedge clk);
                end
                holds_served++;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when no transaction happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transaction", quiet_cycles);
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and verdict.
    initial
    begin
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        send_idle_pct = 7;
        recv_idle_pct = 49;
        hold_requests = 0;
        bytes_sent    = 0;
        repeat (8)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a sync start that is abandoned, a repeated first sync
        // byte with a zero length, and a packet made of the header alone.
        send_byte(SYNC_FIRST);
        send_byte(8'h55);
        send_byte(SYNC_FIRST);
        send_frame(0, 1'b1, 1'b1, NO_CUT);
        send_frame(int'(HDR_LEN), 1'b1, 1'b1, NO_CUT);

        // Sender mostly busy, receiver stalling often.
        send_random_traffic(BYTE_GOAL / 3);

        // Sender gapping often, receiver mostly ready.
        send_idle_pct = 49;
        recv_idle_pct = 7;
        send_random_traffic(2 * BYTE_GOAL / 3);

        // No idling; a long receiver hold-off while a full-length packet and
        // more traffic keep coming, so the block backs up into its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        send_frame(255, 1'b1, 1'b1, NO_CUT);
        send_random_traffic(BYTE_GOAL);

        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (8)
        begin
            @(posedge clk);
        end

        $display("Run covered %0d link bytes and %0d results, with %0d good and %0d bad frame ends,",
                 bytes_seen, results_seen, good_ends, bad_ends);
        $display("under three idling mixes and one long receiver hold-off; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0 && outstanding == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sysex_stream_deframer_core.f
src/ssd_pkg.sv
src/ssd_stream_if.sv
src/ssd_parser.sv
src/ssd_out_queue.sv
src/sysex_stream_deframer_core.sv
src/ssd_checker.sv
tb/ssd_deframer_checker.sv
tb/tb.sv
